>>> sv/ls3_pkg.sv
package ls3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int CW        = 65;    // cofactor
    localparam int DETW      = 98;    // determinant and numerators
    localparam int NW        = DETW + FRAC_BITS;  // shifted numerator magnitude
    localparam int DIV_STEPS = NW;    // one quotient bit per stage

    // Cofactor stage results handed to the product stage.
    typedef struct packed {
        logic signed [CW-1:0] m00, m01, m02;
        logic signed [CW-1:0] m10, m11, m12;
        logic signed [CW-1:0] m20, m21, m22;
    } cof_t;

    // Divider lane: remainder, dividend bits shifting out as quotient bits shift in, result sign.
    typedef struct packed {
        logic [DETW:0]  rem;
        logic [NW-1:0]  num;
        logic           neg;
    } lane_t;

endpackage

>>> sv/ls3_mul.sv
// Signed multiplier: two 33x32 partial products are registered, then summed.
module ls3_mul (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [ls3_pkg::CW-1:0]  a,
    input  logic signed [ls3_pkg::DW-1:0]  b,
    output logic signed [ls3_pkg::DETW-1:0] p
);
    // a = ah*2^32 + al (al unsigned 32 bits, ah signed 33 bits)
    logic        [31:0]  al;
    logic signed [32:0]  ah;
    logic signed [65:0]  pl_next, ph_next;
    logic signed [65:0]  pl_reg, ph_reg;

    assign al = a[31:0];
    assign ah = a[ls3_pkg::CW-1:32];
    assign pl_next = $signed({1'b0, al}) * b;
    assign ph_next = ah * b;

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
    end

    assign p = ls3_pkg::DETW'({{(ls3_pkg::DETW-66){pl_reg[65]}}, pl_reg})
             + (ls3_pkg::DETW'({{(ls3_pkg::DETW-66){ph_reg[65]}}, ph_reg}) <<< 32);
endmodule

>>> sv/linear_system_3x3_inverse_solve.sv
// Solves one 3x3 system A x = b in signed Q16.16 per transfer, one system per cycle unless stalled.
// The pipeline computes cofactors, products, sums, then runs a restoring divider
// of one quotient bit per stage for the three unknowns side by side; its 114
// divider stages make up most of the pipeline. The whole pipeline advances
// together and holds while the result register waits for m_ready.
// A zero determinant returns zeros with singular set; saturated unknowns set overflow.
module linear_system_3x3_inverse_solve (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_coef_r1_c1,
    input  logic signed [31:0] s_coef_r1_c2,
    input  logic signed [31:0] s_coef_r1_c3,
    input  logic signed [31:0] s_rhs_r1,
    input  logic signed [31:0] s_coef_r2_c1,
    input  logic signed [31:0] s_coef_r2_c2,
    input  logic signed [31:0] s_coef_r2_c3,
    input  logic signed [31:0] s_rhs_r2,
    input  logic signed [31:0] s_coef_r3_c1,
    input  logic signed [31:0] s_coef_r3_c2,
    input  logic signed [31:0] s_coef_r3_c3,
    input  logic signed [31:0] s_rhs_r3,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_unknown_1,
    output logic signed [31:0] m_unknown_2,
    output logic signed [31:0] m_unknown_3,
    output logic               m_singular,
    output logic               m_overflow
);
    localparam int CW   = ls3_pkg::CW;
    localparam int DETW = ls3_pkg::DETW;
    localparam int NW   = ls3_pkg::NW;
    localparam int NS   = ls3_pkg::DIV_STEPS;
    localparam int FB   = ls3_pkg::FRAC_BITS;
    // Stages: 0 input, 1 cofactor products, 2 cofactors, 3-4 det/num products,
    // 5 sums, 6 magnitudes, then NS divide stages.
    localparam int PRE = 7;
    localparam int NSTG = PRE + NS;

    logic en;
    logic [NSTG-1:0] vld_reg;

    assign s_ready = !m_valid || m_ready;
    assign en = s_ready;

    // Stage 0: registered inputs.
    logic signed [31:0] a_reg [9];
    logic signed [31:0] b_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0] <= s_coef_r1_c1; a_reg[1] <= s_coef_r1_c2; a_reg[2] <= s_coef_r1_c3;
            a_reg[3] <= s_coef_r2_c1; a_reg[4] <= s_coef_r2_c2; a_reg[5] <= s_coef_r2_c3;
            a_reg[6] <= s_coef_r3_c1; a_reg[7] <= s_coef_r3_c2; a_reg[8] <= s_coef_r3_c3;
            b_reg[0] <= s_rhs_r1; b_reg[1] <= s_rhs_r2; b_reg[2] <= s_rhs_r3;
        end
    end

    // Stage 1: eighteen 32x32 products.
    logic signed [63:0] pp_reg [18];
    logic signed [31:0] a1_reg [3];
    logic signed [31:0] b1_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg[0]  <= a_reg[4] * a_reg[8];  pp_reg[1]  <= a_reg[5] * a_reg[7];
            pp_reg[2]  <= a_reg[1] * a_reg[8];  pp_reg[3]  <= a_reg[2] * a_reg[7];
            pp_reg[4]  <= a_reg[1] * a_reg[5];  pp_reg[5]  <= a_reg[2] * a_reg[4];
            pp_reg[6]  <= a_reg[3] * a_reg[8];  pp_reg[7]  <= a_reg[5] * a_reg[6];
            pp_reg[8]  <= a_reg[0] * a_reg[8];  pp_reg[9]  <= a_reg[2] * a_reg[6];
            pp_reg[10] <= a_reg[0] * a_reg[5];  pp_reg[11] <= a_reg[2] * a_reg[3];
            pp_reg[12] <= a_reg[3] * a_reg[7];  pp_reg[13] <= a_reg[4] * a_reg[6];
            pp_reg[14] <= a_reg[0] * a_reg[7];  pp_reg[15] <= a_reg[1] * a_reg[6];
            pp_reg[16] <= a_reg[0] * a_reg[4];  pp_reg[17] <= a_reg[1] * a_reg[3];
            a1_reg[0] <= a_reg[0]; a1_reg[1] <= a_reg[1]; a1_reg[2] <= a_reg[2];
            b1_reg <= b_reg;
        end
    end

    // Stage 2: signed cofactors (adjugate entries).
    ls3_pkg::cof_t cof_next, cof_reg;
    logic signed [31:0] a2_reg [3];
    logic signed [31:0] b2_reg [3];
    function automatic logic signed [CW-1:0] diff(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
        diff = CW'(x) - CW'(y);
    endfunction
    always_comb begin
        cof_next.m00 =  diff(pp_reg[0],  pp_reg[1]);
        cof_next.m01 = -diff(pp_reg[2],  pp_reg[3]);
        cof_next.m02 =  diff(pp_reg[4],  pp_reg[5]);
        cof_next.m10 = -diff(pp_reg[6],  pp_reg[7]);
        cof_next.m11 =  diff(pp_reg[8],  pp_reg[9]);
        cof_next.m12 = -diff(pp_reg[10], pp_reg[11]);
        cof_next.m20 =  diff(pp_reg[12], pp_reg[13]);
        cof_next.m21 = -diff(pp_reg[14], pp_reg[15]);
        cof_next.m22 =  diff(pp_reg[16], pp_reg[17]);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            cof_reg <= cof_next;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
        end
    end

    // Stages 3-4: twelve 65x32 products, each split in two partial products.
    logic signed [CW-1:0]   ma [12];
    logic signed [31:0]     mb [12];
    logic signed [DETW-1:0] mp [12];
    always_comb begin
        ma[0] = cof_reg.m00; mb[0] = a2_reg[0];
        ma[1] = cof_reg.m10; mb[1] = a2_reg[1];
        ma[2] = cof_reg.m20; mb[2] = a2_reg[2];
        ma[3] = cof_reg.m00; mb[3] = b2_reg[0];
        ma[4] = cof_reg.m01; mb[4] = b2_reg[1];
        ma[5] = cof_reg.m02; mb[5] = b2_reg[2];
        ma[6] = cof_reg.m10; mb[6] = b2_reg[0];
        ma[7] = cof_reg.m11; mb[7] = b2_reg[1];
        ma[8] = cof_reg.m12; mb[8] = b2_reg[2];
        ma[9] = cof_reg.m20; mb[9] = b2_reg[0];
        ma[10] = cof_reg.m21; mb[10] = b2_reg[1];
        ma[11] = cof_reg.m22; mb[11] = b2_reg[2];
    end
    for (genvar g = 0; g < 12; g++) begin : g_mul
        ls3_mul u_mul (.aclk(aclk), .en(en), .a(ma[g]), .b(mb[g]), .p(mp[g]));
    end
    logic signed [DETW-1:0] mp_reg [12];
    always_ff @(posedge aclk) begin
        if (en) mp_reg <= mp;
    end

    // Stage 5: determinant and numerators.
    logic signed [DETW-1:0] det_reg, num_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg    <= mp_reg[0] + mp_reg[1] + mp_reg[2];
            num_reg[0] <= mp_reg[3] + mp_reg[4] + mp_reg[5];
            num_reg[1] <= mp_reg[6] + mp_reg[7] + mp_reg[8];
            num_reg[2] <= mp_reg[9] + mp_reg[10] + mp_reg[11];
        end
    end

    // Stage 6: magnitudes and signs.
    logic            sing_last;
    ls3_pkg::lane_t  lane_reg [NS+1][3];
    logic [DETW-1:0] dpipe_reg [NS+1];
    logic            spipe_reg [NS+1];
    always_ff @(posedge aclk) begin
        if (en) begin
            dpipe_reg[0] <= det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
            spipe_reg[0] <= (det_reg == '0);
            for (int i = 0; i < 3; i++) begin
                lane_reg[0][i].rem <= '0;
                lane_reg[0][i].num <= {(num_reg[i][DETW-1] ? DETW'(-num_reg[i])
                                                           : DETW'(num_reg[i])),
                                       {FB{1'b0}}};
                lane_reg[0][i].neg <= num_reg[i][DETW-1] ^ det_reg[DETW-1];
            end
        end
    end
    assign sing_last = spipe_reg[NS];

    // Divide stages: shift one dividend bit into the remainder, subtract if it fits.
    // The dividend register fills with quotient bits from the bottom as it empties.
    for (genvar s = 0; s < NS; s++) begin : g_div
        ls3_pkg::lane_t nxt [3];
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                logic [DETW:0] r;
                logic [DETW+1:0] t;
                r = {lane_reg[s][i].rem[DETW-1:0], lane_reg[s][i].num[NW-1]};
                t = {1'b0, r} - {2'b00, dpipe_reg[s]};
                nxt[i].neg = lane_reg[s][i].neg;
                if (!t[DETW+1]) begin
                    nxt[i].rem = t[DETW:0];
                    nxt[i].num = {lane_reg[s][i].num[NW-2:0], 1'b1};
                end else begin
                    nxt[i].rem = r;
                    nxt[i].num = {lane_reg[s][i].num[NW-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                lane_reg[s+1] <= nxt;
                dpipe_reg[s+1] <= dpipe_reg[s];
                spipe_reg[s+1] <= spipe_reg[s];
            end
        end
    end

    // Final: sign, saturation, singular override into the result register.
    logic signed [31:0] u_next [3];
    logic               ovf_next;
    always_comb begin
        ovf_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            logic [NW-1:0] q;
            q = lane_reg[NS][i].num;
            if (lane_reg[NS][i].neg) begin
                if (q > NW'(32'h8000_0000)) begin
                    u_next[i] = 32'sh8000_0000; ovf_next = 1'b1;
                end else begin
                    u_next[i] = 32'(-q);
                end
            end else if (q > NW'(32'h7FFF_FFFF)) begin
                u_next[i] = 32'sh7FFF_FFFF; ovf_next = 1'b1;
            end else begin
                u_next[i] = 32'(q);
            end
        end
        if (sing_last) begin
            for (int i = 0; i < 3; i++) u_next[i] = '0;
            ovf_next = 1'b0;
        end
    end

    logic out_v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            vld_reg   <= {vld_reg[NSTG-2:0], s_valid};
            out_v_reg <= vld_reg[NSTG-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_unknown_1 <= u_next[0];
            m_unknown_2 <= u_next[1];
            m_unknown_3 <= u_next[2];
            m_singular  <= sing_last;
            m_overflow  <= ovf_next;
        end
    end
    assign m_valid = out_v_reg;

    // A stalled result holds its first unknown and its singular flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_unknown_1) && $stable(m_singular))
        else $error("result changed while stalled");
    // Singular results carry zeros and no overflow.
    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_unknown_1 == 0 && m_unknown_2 == 0
                                  && m_unknown_3 == 0 && !m_overflow)
        else $error("singular result not zero");
    // The pipeline never advances while the output waits.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
    // An accepted transfer sets the valid bit of the first stage.
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        en && s_valid |=> vld_reg[0])
        else $error("accepted item lost");
endmodule
